>>> rtl/core/mst_pkg.sv
// Shared types, codes and helpers for the min tracking stack.
package mst_pkg;

   localparam int unsigned DEPTH   = 256;
   localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned COUNT_W = 9;
   localparam int unsigned VAL_W   = 32;
   localparam int unsigned DIFF_W  = VAL_W + 1;

   localparam logic [1:0] FUNC_PUSH  = 2'd0;
   localparam logic [1:0] FUNC_POP   = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   localparam logic [COUNT_W-1:0] CAPACITY_RESET = COUNT_W'(256);
   localparam logic [COUNT_W-1:0] DEPTH_COUNT    = COUNT_W'(DEPTH);

   typedef struct packed {
      logic signed [VAL_W-1:0] popped_value;
      logic signed [VAL_W-1:0] top_value;
      logic signed [VAL_W-1:0] min_value;
      logic [COUNT_W-1:0]      depth_now;
      logic [1:0]              status;
   } result_type;

   function automatic logic signed [VAL_W-1:0] decode_top(
      input logic signed [DIFF_W-1:0] diff,
      input logic signed [VAL_W-1:0]  cur_min
   );
      logic [DIFF_W-1:0] sum;
      sum = {cur_min[VAL_W-1], cur_min} + diff;
      return diff[DIFF_W-1] ? cur_min : $signed(sum[VAL_W-1:0]);
   endfunction

endpackage

>>> rtl/core/mst_ifs.sv
// Channel interfaces: request, response and configuration write.
interface mst_req_if;
   import mst_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [1:0]              func;
   logic signed [VAL_W-1:0] value;
   modport source (output valid, func, value, input ready);
   modport sink (input valid, func, value, output ready);
endinterface

interface mst_rsp_if;
   import mst_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] popped_value;
   logic signed [VAL_W-1:0] top_value;
   logic signed [VAL_W-1:0] min_value;
   logic [COUNT_W-1:0]      depth_now;
   logic [1:0]              status;
   modport source (output valid, popped_value, top_value, min_value, depth_now, status,
                   input ready);
   modport sink (input valid, popped_value, top_value, min_value, depth_now, status,
                 output ready);
endinterface

interface mst_csr_if;
   import mst_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/min_tracking_stack_core.sv
// Top level of the min tracking stack: sequencer, difference store, response register.
//
//   channel   direction  payload
//   req_chan  in         func, value
//   rsp_chan  out        popped_value, top_value, min_value, depth_now, status
//   csr_chan  in         data (capacity, always ready)
//
// Push, query and refused operations pass the sequencer's execute and emit states
// before entering the response register; a pop that leaves entries also passes the
// read state, which takes the store read of the new top. The sequencer accepts no
// new transaction until the previous result has entered the response register.
// Reset clears count and minimum and sets capacity to 256; the store is not
// cleared. A stalled response holds in its register and blocks the sequencer hand-off.
module min_tracking_stack_core (
   input  logic      clock,
   input  logic      reset,
   mst_req_if.sink   req_chan,
   mst_rsp_if.source rsp_chan,
   mst_csr_if.sink   csr_chan
);
   import mst_pkg::*;

   logic [COUNT_W-1:0] capacity_ff;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [DIFF_W-1:0]  wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [DIFF_W-1:0]  rd_data;
   logic               res_valid;
   logic               res_ready;
   result_type         res;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_chan.valid) begin
         capacity_ff <= csr_chan.data;
      end
   end

   mst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_func  (req_chan.func),
      .req_value (req_chan.value),
      .capacity  (capacity_ff),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   mst_diff_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (DIFF_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mst_rsp_reg u_rsp (
      .clock    (clock),
      .reset    (reset),
      .in_valid (res_valid),
      .in_ready (res_ready),
      .in_res   (res),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> rtl/core/mst_diff_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
module mst_diff_ram #(
   parameter int unsigned ADDR_W = 8,
   parameter int unsigned DATA_W = 33
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> rtl/core/mst_ctrl.sv
// Stack sequencer: holds the minimum, count and top difference, drives the store.
module mst_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_func,
   input  logic signed [31:0]           req_value,
   input  logic [8:0]                   capacity,
   output logic                         wr_en,
   output logic [mst_pkg::ADDR_W-1:0]   wr_addr,
   output logic [mst_pkg::DIFF_W-1:0]   wr_data,
   output logic                         rd_en,
   output logic [mst_pkg::ADDR_W-1:0]   rd_addr,
   input  logic [mst_pkg::DIFF_W-1:0]   rd_data,
   output logic                         res_valid,
   input  logic                         res_ready,
   output mst_pkg::result_type          res
);
   import mst_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ, S_EMIT} state_type;

   state_type               state_ff, state_in;
   logic [1:0]              func_ff, func_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic signed [VAL_W-1:0] min_ff, min_in;
   logic signed [DIFF_W-1:0] top_diff_ff, top_diff_in;
   result_type              res_ff, res_in;

   logic [COUNT_W-1:0]       limit;
   logic signed [DIFF_W-1:0] push_diff;
   logic signed [DIFF_W-1:0] pop_sum;
   logic signed [DIFF_W-1:0] pop_rest;
   logic [COUNT_W-1:0]       count_m2;

   always_comb begin
      limit     = (capacity > DEPTH_COUNT) ? DEPTH_COUNT : capacity;
      push_diff = $signed({value_ff[VAL_W-1], value_ff}) - $signed({min_ff[VAL_W-1], min_ff});
      pop_sum   = $signed({min_ff[VAL_W-1], min_ff}) + top_diff_ff;
      pop_rest  = $signed({min_ff[VAL_W-1], min_ff}) - top_diff_ff;
      count_m2  = count_ff - COUNT_W'(2);

      state_in    = state_ff;
      func_in     = func_ff;
      value_in    = value_ff;
      count_in    = count_ff;
      min_in      = min_ff;
      top_diff_in = top_diff_ff;
      res_in      = res_ff;
      wr_en       = 1'b0;
      wr_addr     = count_ff[ADDR_W-1:0];
      wr_data     = push_diff;
      rd_en       = 1'b0;
      rd_addr     = count_m2[ADDR_W-1:0];
      req_ready   = 1'b0;
      res_valid   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in  = req_func;
               value_in = req_value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_in.popped_value = '0;
            res_in.status       = STATUS_OK;
            res_in.depth_now    = count_ff;
            res_in.min_value    = (count_ff == '0) ? '0 : min_ff;
            res_in.top_value    = (count_ff == '0) ? '0 : decode_top(top_diff_ff, min_ff);
            state_in            = S_EMIT;
            case (func_ff)
               FUNC_PUSH: begin
                  if (count_ff >= limit) begin
                     res_in.status = STATUS_OVERFLOW;
                  end else begin
                     wr_en = 1'b1;
                     if (count_ff == '0) begin
                        wr_data     = '0;
                        top_diff_in = '0;
                        min_in      = value_ff;
                     end else begin
                        top_diff_in = push_diff;
                        min_in      = (value_ff < min_ff) ? value_ff : min_ff;
                     end
                     count_in         = count_ff + COUNT_W'(1);
                     res_in.depth_now = count_in;
                     res_in.min_value = min_in;
                     res_in.top_value = value_ff;
                  end
               end
               FUNC_POP: begin
                  if (count_ff == '0) begin
                     res_in.status = STATUS_UNDERFLOW;
                  end else begin
                     if (top_diff_ff[DIFF_W-1]) begin
                        res_in.popped_value = min_ff;
                        min_in              = pop_rest[VAL_W-1:0];
                     end else begin
                        res_in.popped_value = pop_sum[VAL_W-1:0];
                     end
                     count_in         = count_ff - COUNT_W'(1);
                     res_in.depth_now = count_in;
                     if (count_ff == COUNT_W'(1)) begin
                        min_in           = '0;
                        res_in.min_value = '0;
                        res_in.top_value = '0;
                     end else begin
                        rd_en            = 1'b1;
                        res_in.min_value = min_in;
                        state_in         = S_READ;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_READ: begin
            top_diff_in      = $signed(rd_data);
            res_in.top_value = decode_top($signed(rd_data), min_ff);
            state_in         = S_EMIT;
         end
         S_EMIT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign res = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         min_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         min_ff   <= min_in;
      end
      func_ff     <= func_in;
      value_ff    <= value_in;
      top_diff_ff <= top_diff_in;
      res_ff      <= res_in;
   end

endmodule

>>> rtl/core/mst_rsp_reg.sv
// Response output register that parts the sequencer from the response channel.
module mst_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  mst_pkg::result_type in_res,
   mst_rsp_if.source           rsp_chan
);
   import mst_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   assign in_ready = !valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         data_ff <= in_res;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.popped_value = data_ff.popped_value;
   assign rsp_chan.top_value    = data_ff.top_value;
   assign rsp_chan.min_value    = data_ff.min_value;
   assign rsp_chan.depth_now    = data_ff.depth_now;
   assign rsp_chan.status       = data_ff.status;

endmodule

>>> rtl/core/mst_checker.sv
// Port-level checker for the min tracking stack and its bind to the top level.
module mst_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_popped_value,
   input logic [31:0] rsp_top_value,
   input logic [31:0] rsp_min_value,
   input logic [8:0]  rsp_depth_now,
   input logic [1:0]  rsp_status
);
   import mst_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_depth_now <= DEPTH_COUNT)
      else $error("depth beyond store size");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_UNDERFLOW |->
         rsp_depth_now == '0 && rsp_popped_value == '0)
      else $error("underflow on a non-empty stack");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_depth_now == '0 |-> rsp_top_value == '0 && rsp_min_value == '0)
      else $error("empty stack reports nonzero top or minimum");

endmodule

bind min_tracking_stack_core mst_checker u_mst_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_popped_value (rsp_chan.popped_value),
   .rsp_top_value    (rsp_chan.top_value),
   .rsp_min_value    (rsp_chan.min_value),
   .rsp_depth_now    (rsp_chan.depth_now),
   .rsp_status       (rsp_chan.status)
);
